// ===== rtl/core/cbez_pkg.sv =====
// Cubic Bezier point generator package: payload structs, widths, reciprocal scaling.
// No dependencies.
`timescale 1ns / 1ps
package cbez_pkg;

    localparam int COORD_W   = 16;
    localparam int SEG_W     = 6;
    localparam int T_W       = 16;
    localparam int MAX_SEGMENTS = 63;
    // Reciprocal of n as ceil(2^RCP_SHIFT / n); exact for numerators below 2^22
    localparam int RCP_SHIFT = 28;
    localparam int RCP_W     = 29;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] ctrl_a_x;
        logic signed [COORD_W-1:0] ctrl_a_y;
        logic signed [COORD_W-1:0] ctrl_b_x;
        logic signed [COORD_W-1:0] ctrl_b_y;
        logic [SEG_W-1:0]          segment_count;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } t_out_item;

    // Per-axis power-basis coefficients
    typedef struct packed {
        logic signed [COORD_W-1:0] p0;
        logic signed [COORD_W-1:0] p3;
        logic signed [19:0]        c;
        logic signed [20:0]        b;
        logic signed [19:0]        a;
    } t_coef;

    // Point request flowing down the pipeline
    typedef struct packed {
        logic [T_W-1:0] t;
        logic           is_start;
        logic           is_end;
    } t_pt_req;

endpackage

// ===== rtl/core/cubic_bezier_point_generator_unit.sv =====
// Top level of the cubic Bezier point generator: sequencer plus two axis pipelines.
// Depends on cbez_pkg, cbez_seq, cbez_axis.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid/o_ready, i_data) takes one curve: four points and a
//   segment count n. n = 0 is accepted and produces nothing. Otherwise n+1
//   points leave on the output channel (o_valid/i_ready, o_data), start point
//   first, end point last with last_point set.
//   The first point appears after the sequencer has latched the item and the
//   point has passed the four-stage multiply pipeline. Throughput: one point per
//   cycle while the receiver takes points; the next item is taken in the cycle
//   after the last point of this one has entered the pipeline.
//   Reset (synchronous, active low) empties the pipeline and the sequencer;
//   no beat is shown after reset until a new item arrives.
//   Receiver stall: with i_ready low and a point at the output, the pipeline holds,
//   so no point is lost or repeated; the sequencer stops issuing meanwhile.
module cubic_bezier_point_generator_unit import cbez_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);
    localparam int DEPTH = 4;

    logic       pt_valid;
    logic       en;
    t_pt_req    pt;
    t_coef      cx, cy;
    logic signed [COORD_W-1:0] ax_point, ay_point;
    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] r_last;

    // Advance when the output slot is empty or being taken
    assign en = !r_vld[DEPTH-1] || i_ready;

    cbez_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_pt_valid (pt_valid),
        .i_pt_ready (en),
        .o_pt       (pt),
        .o_cx       (cx),
        .o_cy       (cy)
    );

    cbez_axis u_ax (
        .i_clk(i_clk), .i_en(en), .i_t(pt.t), .i_coef(cx),
        .i_is_start(pt.is_start), .i_is_end(pt.is_end), .o_point(ax_point)
    );

    cbez_axis u_ay (
        .i_clk(i_clk), .i_en(en), .i_t(pt.t), .i_coef(cy),
        .i_is_start(pt.is_start), .i_is_end(pt.is_end), .o_point(ay_point)
    );

    // Carry valid and last flags alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], pt_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[DEPTH-2:0], pt.is_end};
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_data  = '{point_x: ax_point, point_y: ay_point, last_point: r_last[DEPTH-1]};
endmodule

// ===== rtl/core/cbez_seq.sv =====
// Point sequencer: holds one item, steps the point index, computes t per point.
// Depends on cbez_pkg.
`timescale 1ns / 1ps
module cbez_seq import cbez_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_data,
    output logic     o_pt_valid,
    input  logic     i_pt_ready,
    output t_pt_req  o_pt,
    output t_coef    o_cx,
    output t_coef    o_cy
);
    logic             r_busy;
    logic [SEG_W-1:0] r_n;
    logic [SEG_W-1:0] r_i;
    logic [T_W-1:0]   r_t;
    logic [RCP_W-1:0] r_rcp;
    t_coef            r_cx, r_cy;
    logic [RCP_W-1:0] rcp_tab [1 << SEG_W];
    logic [SEG_W-1:0] n_i;
    logic [21:0]      n_num;
    logic [50:0]      n_prod;

    function automatic t_coef mk(input logic signed [15:0] p0, input logic signed [15:0] p1,
                                 input logic signed [15:0] p2, input logic signed [15:0] p3);
        t_coef k;
        logic signed [20:0] e0, e1, e2, e3;
        begin
            e0 = 21'(p0); e1 = 21'(p1); e2 = 21'(p2); e3 = 21'(p3);
            k.p0 = p0;
            k.p3 = p3;
            k.c  = 20'(21'sd3 * (e1 - e0));
            k.b  = 21'sd3 * (e0 - (e1 <<< 1) + e2);
            k.a  = 20'(e3 - e0 + 21'sd3 * (e1 - e2));
            mk = k;
        end
    endfunction

    // Reciprocal table, ceil(2^RCP_SHIFT / n); entry zero is never used
    assign rcp_tab[0] = '0;
    for (genvar g = 1; g < (1 << SEG_W); g++) begin : g_rcp
        localparam logic [RCP_W-1:0] RCP =
            RCP_W'(((64'd1 << RCP_SHIFT) + 64'(g) - 64'd1) / 64'(g));
        assign rcp_tab[g] = RCP;
    end

    // t of the next point: (i*65536 + n/2) / n by reciprocal multiplication
    assign n_i    = r_i + 1'b1;
    assign n_num  = {n_i, 16'h0} + {16'h0, r_n >> 1};
    assign n_prod = n_num * r_rcp;

    assign o_ready    = !r_busy;
    assign o_pt_valid = r_busy;
    assign o_pt = '{t: r_t, is_start: (r_i == '0), is_end: (r_i == r_n)};
    assign o_cx = r_cx;
    assign o_cy = r_cy;

    // Latch the item, then advance one point per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
            r_n    <= '0;
            r_t    <= '0;
            r_rcp  <= '0;
        end else if (!r_busy) begin
            if (i_valid && i_data.segment_count != '0) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_n    <= i_data.segment_count;
                r_t    <= '0;
                r_rcp  <= rcp_tab[i_data.segment_count];
            end
        end else if (i_pt_ready) begin
            if (r_i == r_n) begin
                r_busy <= 1'b0;
            end
            r_i <= n_i;
            r_t <= n_prod[RCP_SHIFT +: T_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_cx <= mk(i_data.start_x, i_data.ctrl_a_x, i_data.ctrl_b_x, i_data.end_x);
            r_cy <= mk(i_data.start_y, i_data.ctrl_a_y, i_data.ctrl_b_y, i_data.end_y);
        end
    end
endmodule

// ===== rtl/core/cbez_axis.sv =====
// One-axis Bezier evaluation pipeline: four stages, held by a shared enable.
// Depends on cbez_pkg.
`timescale 1ns / 1ps
module cbez_axis import cbez_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [T_W-1:0]            i_t,
    input  t_coef                     i_coef,
    input  logic                      i_is_start,
    input  logic                      i_is_end,
    output logic signed [COORD_W-1:0] o_point
);
    // Stage 1: t^2, c*t
    logic [31:0]        r1_t2;
    logic [T_W-1:0]     r1_t;
    logic signed [36:0] r1_ct;
    t_coef              r1_k;
    logic               r1_s, r1_e;
    // Stage 2: t^3 rounded, b*t^2
    logic [31:0]        r2_t3;
    logic signed [53:0] r2_bt2;
    logic signed [36:0] r2_ct;
    t_coef              r2_k;
    logic               r2_s, r2_e;
    // Stage 3: a*t^3, partial sum
    logic signed [53:0] r3_at3;
    logic signed [55:0] r3_ps;
    t_coef              r3_k;
    logic               r3_s, r3_e;
    logic [47:0]        n_t3w;
    logic signed [56:0] n_sum;
    logic signed [24:0] n_q;

    assign n_t3w = r1_t2 * r1_t + 48'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t2  <= i_t * i_t;
            r1_t   <= i_t;
            r1_ct  <= i_coef.c * $signed({1'b0, i_t});
            r1_k   <= i_coef;
            r1_s   <= i_is_start;
            r1_e   <= i_is_end;
            r2_t3  <= n_t3w[47:16];
            r2_bt2 <= r1_k.b * $signed({1'b0, r1_t2});
            r2_ct  <= r1_ct;
            r2_k   <= r1_k;
            r2_s   <= r1_s;
            r2_e   <= r1_e;
            r3_at3 <= r2_k.a * $signed({1'b0, r2_t3});
            r3_ps  <= 56'(r2_bt2) + (56'(r2_ct) <<< 16) + (56'(r2_k.p0) <<< 32);
            r3_k   <= r2_k;
            r3_s   <= r2_s;
            r3_e   <= r2_e;
        end
    end

    // Round half up and saturate; endpoints pass through
    assign n_sum = 57'(r3_ps) + 57'(r3_at3) + (57'sd1 <<< 31);
    assign n_q   = n_sum[56:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r3_s) begin
                o_point <= r3_k.p0;
            end else if (r3_e) begin
                o_point <= r3_k.p3;
            end else if (n_q > 25'sd32767) begin
                o_point <= 16'sh7fff;
            end else if (n_q < -25'sd32768) begin
                o_point <= -16'sh8000;
            end else begin
                o_point <= n_q[15:0];
            end
        end
    end
endmodule
